FILE: rtl/rsi_pkg.sv
// Shared constants and types for the ray-sphere intersection pipeline.
package rsi_pkg;

    localparam int DIR_W    = 32;  // direction word, signed Q1.30
    localparam int DIR_FRAC = 30;

    typedef enum logic [1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_CENTER_Z = 2'd2,
        CFG_RADIUS   = 2'd3
    } t_cfg_idx;

endpackage

FILE: rtl/rsi_if.sv
// Ray and result channel interfaces.
interface rsi_ray_if #(parameter int COORD_WIDTH = 32);
    import rsi_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] origin_x;
    logic signed [COORD_WIDTH-1:0] origin_y;
    logic signed [COORD_WIDTH-1:0] origin_z;
    logic signed [DIR_W-1:0]       dir_x;
    logic signed [DIR_W-1:0]       dir_y;
    logic signed [DIR_W-1:0]       dir_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    output ready);
endinterface

interface rsi_hit_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] distance;

    modport source (output valid, hit, distance, input ready);
    modport sink   (input valid, hit, distance, output ready);
endinterface

FILE: rtl/rsi_front.sv
// Front stages: offset, products, dot/length sums, h squared, discriminant.
module rsi_front #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [COORD_WIDTH-1:0]          i_org [3],
    input  logic signed [rsi_pkg::DIR_W-1:0]       i_dir [3],
    input  logic signed [COORD_WIDTH-1:0]          i_ctr [3],
    input  logic        [COORD_WIDTH-2:0]          i_radius,
    output logic                                   o_valid,
    input  logic                                   i_en_down,
    output logic                                   o_hit,
    output logic signed [COORD_WIDTH+4:0]          o_h,
    output logic        [2*COORD_WIDTH+9:0]        o_disc
);
    import rsi_pkg::*;

    localparam int VW  = COORD_WIDTH + 1;
    localparam int PW  = VW + DIR_W;
    localparam int SW  = PW + 2;
    localparam int HW  = SW - DIR_FRAC;
    localparam int QW  = 2 * VW;
    localparam int CSW = QW + 2;
    localparam int RRW = 2 * (COORD_WIDTH - 1);
    localparam int LO  = HW / 2;
    localparam int HI  = HW - LO;
    localparam int DQW = 2 * HW + 1;

    logic en0, en1, en2, en3, en4;
    logic r_vld0, r_vld1, r_vld2, r_vld3, r_vld4;

    logic signed [VW-1:0]    r_v   [3];
    logic signed [DIR_W-1:0] r_d   [3];
    logic signed [PW-1:0]    r_vd  [3];
    logic signed [QW-1:0]    r_vv  [3];
    logic        [RRW-1:0]   r_rr;
    logic signed [HW-1:0]    r_h2, r_h3, r_h4;
    logic signed [CSW-1:0]   r_cs2, r_cs3;
    logic        [HW+LO-1:0] r_plo;
    logic        [HW+HI-1:0] r_phi;
    logic                    r_hit4;
    logic        [2*HW-1:0]  r_disc4;

    logic signed [SW-1:0]    n_hsum;
    logic signed [CSW-1:0]   n_cs;
    logic        [HW-1:0]    n_hmag;
    logic        [2*HW-1:0]  n_hh;
    logic signed [DQW-1:0]   n_dq;

    assign en4 = !r_vld4 || i_en_down;
    assign en3 = !r_vld3 || en4;
    assign en2 = !r_vld2 || en3;
    assign en1 = !r_vld1 || en2;
    assign en0 = !r_vld0 || en1;
    assign o_ready = en0;

    always_comb begin
        n_hsum = SW'(r_vd[0]) + SW'(r_vd[1]) + SW'(r_vd[2]);
        n_cs   = CSW'(r_vv[0]) + CSW'(r_vv[1]) + CSW'(r_vv[2])
               - $signed({2'b00, r_rr});
        n_hmag = r_h2[HW-1] ? HW'(-r_h2) : HW'(r_h2);
        n_hh   = (2*HW)'(r_plo) + ((2*HW)'(r_phi) << LO);
        n_dq   = $signed({1'b0, n_hh}) - DQW'(r_cs3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            if (en0) r_vld0 <= i_valid;
            if (en1) r_vld1 <= r_vld0;
            if (en2) r_vld2 <= r_vld1;
            if (en3) r_vld3 <= r_vld2;
            if (en4) r_vld4 <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (en0) begin
                r_v[i] <= VW'(i_org[i]) - VW'(i_ctr[i]);
                r_d[i] <= i_dir[i];
            end
            if (en1) begin
                r_vd[i] <= PW'(r_v[i]) * PW'(r_d[i]);
                r_vv[i] <= QW'(r_v[i]) * QW'(r_v[i]);
            end
        end
        if (en1) r_rr <= RRW'(i_radius) * RRW'(i_radius);
        if (en2) begin
            r_h2  <= n_hsum[SW-1:DIR_FRAC];  // floor shift to Q16.16
            r_cs2 <= n_cs;
        end
        if (en3) begin
            r_plo <= (HW+LO)'(n_hmag) * (HW+LO)'(n_hmag[LO-1:0]);
            r_phi <= (HW+HI)'(n_hmag) * (HW+HI)'(n_hmag[HW-1:LO]);
            r_h3  <= r_h2;
            r_cs3 <= r_cs2;
        end
        if (en4) begin
            r_hit4  <= !n_dq[DQW-1] && (n_dq != '0);
            r_disc4 <= n_dq[DQW-2:0];
            r_h4    <= r_h3;
        end
    end

    assign o_valid = r_vld4;
    assign o_hit   = r_hit4;
    assign o_h     = r_h4;
    assign o_disc  = r_disc4;
endmodule

FILE: rtl/rsi_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module rsi_sqrt #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_en_up,
    input  logic                              i_hit,
    input  logic signed [COORD_WIDTH+4:0]     i_h,
    input  logic        [2*COORD_WIDTH+9:0]   i_disc,
    output logic                              o_valid,
    input  logic                              i_en_down,
    output logic                              o_hit,
    output logic signed [COORD_WIDTH+4:0]     o_h,
    output logic        [COORD_WIDTH+4:0]     o_root
);
    localparam int HW = COORD_WIDTH + 5;
    localparam int DW = 2 * HW;

    logic                 s_vld [HW+1];
    logic                 s_hit [HW+1];
    logic signed [HW-1:0] s_h   [HW+1];
    logic        [DW-1:0] s_rem [HW+1];
    logic        [HW-1:0] s_q   [HW+1];
    logic                 s_en  [HW+1];

    logic                 r_vld [HW];
    logic                 r_hit [HW];
    logic signed [HW-1:0] r_h   [HW];
    logic        [DW-1:0] r_rem [HW];
    logic        [HW-1:0] r_q   [HW];

    assign s_vld[0] = i_valid;
    assign s_hit[0] = i_hit;
    assign s_h[0]   = i_h;
    assign s_rem[0] = i_disc;
    assign s_q[0]   = '0;
    assign s_en[HW] = i_en_down;
    assign o_en_up  = s_en[0];

    for (genvar k = 0; k < HW; k++) begin : g_stage
        localparam int B = HW - 1 - k;
        logic [DW-1:0] trial;

        assign s_en[k] = !r_vld[k] || s_en[k+1];
        // (q + 2^B)^2 - q^2 = q*2^(B+1) + 2^(2B)
        assign trial = (DW'(s_q[k]) << (B + 1)) + (DW'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (s_en[k]) begin
                r_vld[k] <= s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (s_en[k]) begin
                r_hit[k] <= s_hit[k];
                r_h[k]   <= s_h[k];
                if (s_rem[k] >= trial) begin
                    r_rem[k] <= s_rem[k] - trial;
                    r_q[k]   <= s_q[k] | (HW'(1) << B);
                end else begin
                    r_rem[k] <= s_rem[k];
                    r_q[k]   <= s_q[k];
                end
            end
        end

        assign s_vld[k+1] = r_vld[k];
        assign s_hit[k+1] = r_hit[k];
        assign s_h[k+1]   = r_h[k];
        assign s_rem[k+1] = r_rem[k];
        assign s_q[k+1]   = r_q[k];
    end

    assign o_valid = s_vld[HW];
    assign o_hit   = s_hit[HW];
    assign o_h     = s_h[HW];
    assign o_root  = s_q[HW];
endmodule

FILE: rtl/rsi_root.sv
// Root selection, saturation and the output register.
module rsi_root #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_en_up,
    input  logic                           i_hit,
    input  logic signed [COORD_WIDTH+4:0]  i_h,
    input  logic        [COORD_WIDTH+4:0]  i_s,
    rsi_hit_if.source                      o_res
);
    localparam int HW = COORD_WIDTH + 5;
    localparam int XW = HW + 2;

    logic                          r_vld;
    logic                          r_hit;
    logic signed [COORD_WIDTH-1:0] r_dist;
    logic                          en;

    logic signed [XW-1:0]          hx, sx, near_r, far_r, root;
    logic signed [XW-1:0]          lim_hi, lim_lo;
    logic signed [COORD_WIDTH-1:0] n_dist;

    assign en      = !r_vld || o_res.ready;
    assign o_en_up = en;

    always_comb begin
        hx     = XW'(i_h);
        sx     = $signed({2'b00, i_s});
        near_r = -hx - sx - XW'(1);  // near root less one LSB
        far_r  = sx - hx;
        root   = (near_r > 0) ? near_r : far_r;
        lim_hi = XW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
        lim_lo = -lim_hi - XW'(1);
        if (!i_hit)
            n_dist = -(COORD_WIDTH'(1) << FRAC_BITS);
        else if (root > lim_hi)
            n_dist = lim_hi[COORD_WIDTH-1:0];
        else if (root < lim_lo)
            n_dist = lim_lo[COORD_WIDTH-1:0];
        else
            n_dist = root[COORD_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit  <= i_hit;
            r_dist <= n_dist;
        end
    end

    assign o_res.valid    = r_vld;
    assign o_res.hit      = r_hit;
    assign o_res.distance = r_dist;
endmodule

FILE: rtl/ray_sphere_intersection_top.sv
// Top level of the ray-sphere intersection pipeline.
//  channel | dir | handshake   | payload
//  i_ray   | in  | valid/ready | origin_x/y/z Q16.16, dir_x/y/z Q1.30
//  o_res   | out | valid/ready | hit, distance Q16.16
//  cfg     | in  | i_cfg_we    | i_cfg_idx, i_cfg_data
// One ray per cycle while o_res is not stalled; most of the depth comes from the
// square root pipeline that resolves one root bit per stage.
// Each stage advances when it is empty or its successor advances, so a stall
// only holds stages that are full; bubbles are squeezed out.
// Synchronous reset clears the valid bits and the sphere center, and sets the radius to 1.0.
module ray_sphere_intersection_top #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rsi_ray_if.sink                     i_ray,
    rsi_hit_if.source                   o_res,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]      i_cfg_data
);
    import rsi_pkg::*;

    localparam int HW = COORD_WIDTH + 5;

    logic signed [COORD_WIDTH-1:0] r_ctr [3];
    logic        [COORD_WIDTH-2:0] r_radius;

    logic signed [COORD_WIDTH-1:0] org [3];
    logic signed [DIR_W-1:0]       dir [3];

    logic                 f_valid, f_hit, sq_en_up;
    logic signed [HW-1:0] f_h;
    logic [2*HW-1:0]      f_disc;
    logic                 q_valid, q_hit, rt_en_up;
    logic signed [HW-1:0] q_h;
    logic [HW-1:0]        q_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr[0] <= '0;
            r_ctr[1] <= '0;
            r_ctr[2] <= '0;
            r_radius <= (COORD_WIDTH-1)'(1) << FRAC_BITS;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER_X: r_ctr[0] <= i_cfg_data;
                CFG_CENTER_Y: r_ctr[1] <= i_cfg_data;
                CFG_CENTER_Z: r_ctr[2] <= i_cfg_data;
                CFG_RADIUS:   r_radius <= i_cfg_data[COORD_WIDTH-2:0];
                default:      r_radius <= r_radius;
            endcase
        end
    end

    assign org[0] = i_ray.origin_x;
    assign org[1] = i_ray.origin_y;
    assign org[2] = i_ray.origin_z;
    assign dir[0] = i_ray.dir_x;
    assign dir[1] = i_ray.dir_y;
    assign dir[2] = i_ray.dir_z;

    rsi_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_ray.valid),
        .o_ready  (i_ray.ready),
        .i_org    (org),
        .i_dir    (dir),
        .i_ctr    (r_ctr),
        .i_radius (r_radius),
        .o_valid  (f_valid),
        .i_en_down(sq_en_up),
        .o_hit    (f_hit),
        .o_h      (f_h),
        .o_disc   (f_disc)
    );

    rsi_sqrt #(.COORD_WIDTH(COORD_WIDTH)) u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (f_valid),
        .o_en_up  (sq_en_up),
        .i_hit    (f_hit),
        .i_h      (f_h),
        .i_disc   (f_disc),
        .o_valid  (q_valid),
        .i_en_down(rt_en_up),
        .o_hit    (q_hit),
        .o_h      (q_h),
        .o_root   (q_root)
    );

    rsi_root #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_root (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .o_en_up(rt_en_up),
        .i_hit  (q_hit),
        .i_h    (q_h),
        .i_s    (q_root),
        .o_res  (o_res)
    );
endmodule

FILE: rtl/rsi_checker.sv
// Port-level checks for the ray-sphere intersection top level.
module rsi_checker #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_out_hit,
    input logic signed [COORD_WIDTH-1:0] i_out_dist
);
    localparam logic signed [COORD_WIDTH-1:0] MissDist =
        -(COORD_WIDTH'(1) << FRAC_BITS);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_hit)
            && $stable(i_out_dist))
        else $error("result changed while stalled");

    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_hit |-> i_out_dist == MissDist)
        else $error("miss without the miss distance");

    a_rst: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with an empty output register");
endmodule

bind ray_sphere_intersection_top rsi_checker #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
) u_rsi_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_ray.valid),
    .i_in_ready (i_ray.ready),
    .i_out_valid(o_res.valid),
    .i_out_ready(o_res.ready),
    .i_out_hit  (o_res.hit),
    .i_out_dist (o_res.distance)
);

FILE: tb/rsi_tb_pkg.sv
// Testbench types and codes shared between the stimulus top and the checker.
package rsi_tb_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 32;
    localparam int FB = 16;

    typedef struct packed {
        logic        hit;
        logic [CW-1:0] distance;
    } t_hit_rec;
endpackage

FILE: tb/rsi_checker.sv
// Checker: watches the ray, result and config ports, predicts hits and compares them.
module rsi_scoreboard
    import rsi_pkg::*;
    import rsi_tb_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    rsi_ray_if.sink       ray_mon,
    rsi_hit_if.sink       res_mon,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [CW-1:0] i_cfg_data,
    output int            o_errors,
    output int            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [CW-1:0] sph_c [3];
    logic [CW-2:0]        sph_r;
    t_hit_rec             hit_q[$];

    // integer square root of a 128-bit nonnegative value, floor
    function automatic logic [63:0] isqrt128(input logic [127:0] d);
        logic [63:0]  r;
        logic [63:0]  t;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if ({64'd0, t} * {64'd0, t} <= d) r = t;
        end
        return r;
    endfunction

    function automatic t_hit_rec trace_ray(input logic signed [CW-1:0] org [3],
                                           input logic signed [31:0] dir [3]);
        logic signed [127:0] hsum, csum, dq, hh, root, v, lim;
        logic signed [127:0] h, s;
        t_hit_rec res;
        hsum = '0;
        csum = '0;
        for (int i = 0; i < 3; i++) begin
            v = 128'(org[i]) - 128'(sph_c[i]);
            hsum += v * 128'(dir[i]);
            csum += v * v;
        end
        h = hsum >>> DIR_FRAC;
        csum -= 128'($unsigned(sph_r)) * 128'($unsigned(sph_r));
        hh = h * h;
        dq = hh - csum;
        if (dq <= 0) begin
            res.hit = 1'b0;
            res.distance = -(CW'(1) << FB);
            return res;
        end
        s = 128'(isqrt128(dq));
        root = -h - s - 1;
        if (root <= 0) root = s - h;
        lim = (128'sd1 <<< (CW - 1)) - 1;
        if (root > lim) root = lim;
        if (root < -lim - 1) root = -lim - 1;
        res.hit = 1'b1;
        res.distance = root[CW-1:0];
        return res;
    endfunction

    assign o_pending = hit_q.size();

    always @(posedge i_clk) begin
        logic signed [CW-1:0] org [3];
        logic signed [31:0]   dir [3];
        t_hit_rec exp_r;
        if (!i_rst_n) begin
            sph_c[0] <= '0;
            sph_c[1] <= '0;
            sph_c[2] <= '0;
            sph_r    <= (CW-1)'(1) << FB;
            hit_q.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_CENTER_X: sph_c[0] <= i_cfg_data;
                    CFG_CENTER_Y: sph_c[1] <= i_cfg_data;
                    CFG_CENTER_Z: sph_c[2] <= i_cfg_data;
                    CFG_RADIUS:   sph_r    <= i_cfg_data[CW-2:0];
                    default: ;
                endcase
            end
            if (ray_mon.valid && ray_mon.ready) begin
                org[0] = ray_mon.origin_x;
                org[1] = ray_mon.origin_y;
                org[2] = ray_mon.origin_z;
                dir[0] = ray_mon.dir_x;
                dir[1] = ray_mon.dir_y;
                dir[2] = ray_mon.dir_z;
                hit_q.push_back(trace_ray(org, dir));
            end
            if (res_mon.valid && res_mon.ready) begin
                if (hit_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected transaction: hit=%0b dist=%h",
                                                res_mon.hit, res_mon.distance);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = hit_q.pop_front();
                    if (exp_r.hit !== res_mon.hit || exp_r.distance !== res_mon.distance) begin
                        if (o_errors < 10)
                            $display("mismatch: exp hit=%0b dist=%h, got hit=%0b dist=%h",
                                     exp_r.hit, exp_r.distance, res_mon.hit, res_mon.distance);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: tb/tb.sv
// Testbench top: clock, reset, ray stimulus, config phases and verdict.
module tb;
    import rsi_pkg::*;
    import rsi_tb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY  = CW + 11;
    localparam int WD_LIMIT = 4000;
    localparam logic signed [31:0] ONE_DIR = 32'sd1 << DIR_FRAC;

    logic          i_clk;
    logic          i_rst_n;
    logic          cfg_we;
    logic [1:0]    cfg_idx;
    logic [CW-1:0] cfg_data;
    int            errors;
    int            pending;
    int            idle_cycles;
    int            stall_mode;
    logic          timed_out;

    rsi_ray_if #(.COORD_WIDTH(CW)) ray_ch ();
    rsi_hit_if #(.COORD_WIDTH(CW)) res_ch ();

    ray_sphere_intersection_top #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ray(ray_ch.sink), .o_res(res_ch.source),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    rsi_scoreboard u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .ray_mon(ray_ch.sink), .res_mon(res_ch.sink),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // receiver backpressure, pattern changes every so often
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= ($urandom_range(0, 3) != 0);
                2: res_ch.ready <= ($urandom_range(0, 1) != 0);
                default: res_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (ray_ch.valid && ray_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT) timed_out <= 1'b1;
    end

    initial begin
        wait (timed_out === 1'b1);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [CW-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic set_sphere(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                              input logic [CW-1:0] cz, input logic [CW-1:0] rad);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_CENTER_Z, cz);
        write_reg(CFG_RADIUS, rad);
    endtask

    // drive one ray and hold it until accepted; ends at a falling edge
    task automatic send_ray(input logic [CW-1:0] ox, input logic [CW-1:0] oy,
                            input logic [CW-1:0] oz, input logic [31:0] dx,
                            input logic [31:0] dy, input logic [31:0] dz);
        ray_ch.valid    <= 1'b1;
        ray_ch.origin_x <= ox;
        ray_ch.origin_y <= oy;
        ray_ch.origin_z <= oz;
        ray_ch.dir_x    <= dx;
        ray_ch.dir_y    <= dy;
        ray_ch.dir_z    <= dz;
        do @(posedge i_clk); while (!ray_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic gap(input int n);
        ray_ch.valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain;
        ray_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    function automatic logic [CW-1:0] rnd_coord(input int span);
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return {CW{1'b1}} ^ (CW'($urandom_range(0, 3)) << (CW - 2));
            default: return CW'($signed(32'($urandom_range(0, 2 * span)) - span));
        endcase
    endfunction

    function automatic logic [31:0] rnd_dir();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) return $urandom();
        if (sel == 1) return ONE_DIR;
        if (sel == 2) return -ONE_DIR;
        return 32'($signed(32'($urandom_range(0, 32'h8000_0000)) - ONE_DIR));
    endfunction

    // mostly random directions with components within +-1.0, origins mostly within +-span
    task automatic random_rays(input int n, input int span);
        int burst;
        int sent;
        sent = 0;
        while (sent < n) begin
            burst = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            for (int k = 0; k < burst && sent < n; k++) begin
                send_ray(rnd_coord(span), rnd_coord(span), rnd_coord(span),
                         rnd_dir(), rnd_dir(), rnd_dir());
                sent++;
            end
            if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 6));
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        stall_mode   = 0;
        idle_cycles  = 0;
        timed_out    = 1'b0;
        ray_ch.valid = 1'b0;
        ray_ch.origin_x = '0;
        ray_ch.origin_y = '0;
        ray_ch.origin_z = '0;
        ray_ch.dir_x = '0;
        ray_ch.dir_y = '0;
        ray_ch.dir_z = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed, reset sphere (unit radius at origin)
        send_ray(-(CW'(5) << FB), '0, '0, ONE_DIR, '0, '0);        // hit from outside
        send_ray('0, '0, '0, '0, ONE_DIR, '0);                     // inside: far root
        send_ray(CW'(5) << FB, '0, '0, ONE_DIR, '0, '0);           // sphere behind ray
        send_ray(-(CW'(5) << FB), CW'(1) << FB, '0, ONE_DIR, '0, '0); // tangent
        send_ray(-(CW'(5) << FB), CW'(3) << FB, '0, ONE_DIR, '0, '0); // clean miss
        send_ray('0, '0, -(CW'(3) << FB), '0, '0, ONE_DIR >>> 1);  // short direction
        send_ray('0, '0, -(CW'(3) << FB), '0, '0, 32'h7fff_ffff);  // long direction
        send_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, -ONE_DIR, -ONE_DIR, -ONE_DIR);
        send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, ONE_DIR, ONE_DIR, ONE_DIR);
        send_ray(32'h8000_0000, '0, '0, 32'h8000_0000, '0, '0);
        send_ray(32'h7fff_ffff, '0, '0, 32'h8000_0000, '0, '0);
        send_ray('1, '1, '1, '1, '1, '1);
        drain();

        // huge sphere: saturated distances
        set_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        send_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, ONE_DIR, ONE_DIR, ONE_DIR);
        send_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, -ONE_DIR, '0, '0);
        send_ray('0, '0, '0, '0, '0, '0);
        random_rays(60, 32'h7fff_0000);
        drain();

        // zero radius, off-origin center
        set_sphere(32'h7fff_ffff, 32'h0003_0000, 32'hfffe_8000, '0);
        send_ray('0, CW'(3) << FB, 32'hfffe_8000, ONE_DIR, '0, '0);
        random_rays(60, 32'h0010_0000);
        drain();

        // moderate sphere, bulk of the random rays
        set_sphere(32'h0002_0000, 32'hffff_0000, 32'h0000_8000, 32'h0004_0000);
        random_rays(300, 32'h000c_0000);
        drain();

        set_sphere(32'h1234_5678, 32'hedcb_a988, 32'h0000_0001, 32'h0100_0000);
        random_rays(180, 32'h7fff_0000);
        drain();

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
